// ===== rtl/pkbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pkbd_pkg
// Shared types and codes of the prefix key block entry decoder: channel
// words, the command word that runs from the parser to the emitter, and the
// result kinds and error codes.
// ----------------------------------------------------------------------------
package pkbd_pkg;

  // Largest key length the design supports, and the counter width for it.
  localparam int KEY_LEN_LIMIT   = 64;
  localparam int DEF_MAX_KEY_LEN = 64;
  localparam int KLEN_W          = $clog2(KEY_LEN_LIMIT + 1);

  // Command queue between parser and emitter.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);

  // Result kinds.
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OVERLONG = 3'd1;
  localparam logic [2:0] ERR_SHARED   = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  // Command operations.
  localparam logic [2:0] OP_KEY    = 3'd0;
  localparam logic [2:0] OP_VALUE  = 3'd1;
  localparam logic [2:0] OP_REPLAY = 3'd2;
  localparam logic [2:0] OP_MARKER = 3'd3;
  localparam logic [2:0] OP_ERROR  = 3'd4;

  typedef struct packed {
    logic [7:0] block_byte;
    logic       region_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] out_byte;
    logic [5:0] key_position;
    logic       entry_last;
    logic [2:0] error_code;
  } out_word_t;

  // cnt is the key position of a key byte or the length of a replay.
  typedef struct packed {
    logic [2:0]        op;
    logic [7:0]        data;
    logic [KLEN_W-1:0] cnt;
    logic              last;
    logic [2:0]        err;
    logic              trunc;
  } cmd_t;

endpackage

// ===== rtl/pkbd_front.sv =====
// ----------------------------------------------------------------------------
// pkbd_front
// Entry parser. Decodes the three varint header fields, tracks the key and
// value byte counts and the previous key length, checks the entry for
// errors and issues one command word per byte that produces results.
// ----------------------------------------------------------------------------
module pkbd_front #(
  parameter int MAX_KEY_LEN = pkbd_pkg::DEF_MAX_KEY_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  pkbd_pkg::in_word_t in_word,
  output logic              push,
  output pkbd_pkg::cmd_t    push_cmd
);
  import pkbd_pkg::*;

  localparam logic [2:0] PH_SHARED    = 3'd0;
  localparam logic [2:0] PH_NONSHARED = 3'd1;
  localparam logic [2:0] PH_VALLEN    = 3'd2;
  localparam logic [2:0] PH_KEY       = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;
  localparam logic [2:0] PH_DISCARD   = 3'd5;

  logic [2:0]        phase, phase_next;
  logic [31:0]       vacc, vacc_next;
  logic [2:0]        vcnt, vcnt_next;
  logic [KLEN_W-1:0] shared_len, shared_len_next;
  logic [KLEN_W-1:0] key_length, key_length_next;
  logic [KLEN_W-1:0] nonshared_left, nonshared_left_next;
  logic [31:0]       value_left, value_left_next;

  logic [7:0]        b;
  logic [5:0]        shamt;
  logic [31:0]       vacc_new;
  logic [2:0]        vcnt_inc;
  logic              done;
  logic              last;
  logic              open;
  logic              has_cmd;
  cmd_t              cmd;

  always_comb begin
    b     = in_word.block_byte;
    // Seven payload bits per varint byte.
    shamt = {vcnt, 3'b000} - {3'b000, vcnt};
    vacc_new = vacc | (32'(b[6:0]) << shamt);
    vcnt_inc = vcnt + 3'd1;

    phase_next          = phase;
    vacc_next           = vacc;
    vcnt_next           = vcnt;
    shared_len_next     = shared_len;
    key_length_next     = key_length;
    nonshared_left_next = nonshared_left;
    value_left_next     = value_left;
    has_cmd             = 1'b0;
    cmd                 = '0;
    done                = 1'b0;
    last                = 1'b0;
    open                = 1'b0;

    case (phase)
      PH_SHARED, PH_NONSHARED, PH_VALLEN: begin
        vacc_next = vacc_new;
        vcnt_next = vcnt_inc;
        if (b[7]) begin
          if (vcnt_inc >= 3'd5) begin
            has_cmd     = 1'b1;
            cmd.op      = OP_ERROR;
            cmd.last    = 1'b1;
            cmd.err     = ERR_OVERLONG;
            phase_next  = PH_DISCARD;
            vacc_next   = '0;
            vcnt_next   = '0;
          end
        end else begin
          vacc_next = '0;
          vcnt_next = '0;
          if (phase == PH_SHARED) begin
            if (vacc_new > 32'(key_length)) begin
              has_cmd    = 1'b1;
              cmd.op     = OP_ERROR;
              cmd.last   = 1'b1;
              cmd.err    = ERR_SHARED;
              phase_next = PH_DISCARD;
            end else begin
              shared_len_next = KLEN_W'(vacc_new);
              phase_next      = PH_NONSHARED;
            end
          end else if (phase == PH_NONSHARED) begin
            if (vacc_new > (32'(MAX_KEY_LEN) - 32'(shared_len))) begin
              has_cmd    = 1'b1;
              cmd.op     = OP_ERROR;
              cmd.last   = 1'b1;
              cmd.err    = ERR_OVERFLOW;
              phase_next = PH_DISCARD;
            end else begin
              nonshared_left_next = KLEN_W'(vacc_new);
              phase_next          = PH_VALLEN;
            end
          end else begin
            done            = (nonshared_left == '0) && (vacc_new == '0);
            value_left_next = vacc_new;
            key_length_next = shared_len;
            if ((!in_word.region_end || done) && (shared_len != '0)) begin
              has_cmd  = 1'b1;
              cmd.op   = OP_REPLAY;
              cmd.cnt  = shared_len;
              cmd.last = done;
            end else if (done) begin
              has_cmd  = 1'b1;
              cmd.op   = OP_MARKER;
              cmd.last = 1'b1;
            end
            if (done) begin
              phase_next = PH_SHARED;
            end else if (nonshared_left != '0) begin
              phase_next = PH_KEY;
            end else begin
              phase_next = PH_VALUE;
            end
          end
        end
      end
      PH_KEY: begin
        key_length_next     = key_length + KLEN_W'(1);
        nonshared_left_next = nonshared_left - KLEN_W'(1);
        last = (nonshared_left_next == '0) && (value_left == '0);
        has_cmd  = 1'b1;
        cmd.op   = OP_KEY;
        cmd.data = b;
        cmd.cnt  = key_length;
        cmd.last = last;
        if (nonshared_left_next == '0) begin
          phase_next = last ? PH_SHARED : PH_VALUE;
        end
      end
      PH_VALUE: begin
        value_left_next = value_left - 32'd1;
        last     = (value_left_next == '0);
        has_cmd  = 1'b1;
        cmd.op   = OP_VALUE;
        cmd.data = b;
        cmd.last = last;
        if (last) begin
          phase_next = PH_SHARED;
        end
      end
      default: begin
      end
    endcase

    if (in_word.region_end) begin
      open = (phase_next == PH_SHARED) ? (vcnt_next != '0) : (phase_next != PH_DISCARD);
      if (open) begin
        // A key or value byte may share its word with the truncation error.
        if (has_cmd) begin
          cmd.trunc = 1'b1;
        end else begin
          has_cmd  = 1'b1;
          cmd.op   = OP_ERROR;
          cmd.last = 1'b1;
          cmd.err  = ERR_TRUNC;
        end
      end
      phase_next          = PH_SHARED;
      vacc_next           = '0;
      vcnt_next           = '0;
      shared_len_next     = '0;
      key_length_next     = '0;
      nonshared_left_next = '0;
      value_left_next     = '0;
    end
  end

  assign push     = accept && has_cmd;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SHARED;
      vacc           <= '0;
      vcnt           <= '0;
      shared_len     <= '0;
      key_length     <= '0;
      nonshared_left <= '0;
      value_left     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      vacc           <= vacc_next;
      vcnt           <= vcnt_next;
      shared_len     <= shared_len_next;
      key_length     <= key_length_next;
      nonshared_left <= nonshared_left_next;
      value_left     <= value_left_next;
    end
  end

endmodule

// ===== rtl/pkbd_queue.sv =====
// ----------------------------------------------------------------------------
// pkbd_queue
// Small command queue that lets the parser run ahead of the emitter.
// ----------------------------------------------------------------------------
module pkbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pkbd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output pkbd_pkg::cmd_t head
);
  import pkbd_pkg::*;

  cmd_t               entries [CMDQ_DEPTH];
  logic [CMDQ_PW-1:0] wr_ptr;
  logic [CMDQ_PW-1:0] rd_ptr;
  logic [CMDQ_PW:0]   count;

  assign full       = (count == (CMDQ_PW + 1)'(CMDQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CMDQ_PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + CMDQ_PW'(1);
      end
      if (push && !pop) begin
        count <= count + (CMDQ_PW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (CMDQ_PW + 1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (CMDQ_PW + 1)'(CMDQ_DEPTH))
    else $error("command queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("command queue popped while empty");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + (CMDQ_PW + 1)'(1)))
    else $error("command queue count did not grow on push");
`endif

endmodule

// ===== rtl/pkbd_back.sv =====
// ----------------------------------------------------------------------------
// pkbd_back
// Result emitter. Executes parser commands: stores new key bytes in the key
// memory, replays shared key prefixes from it one byte a cycle while the
// result channel is not stalled, and drives the registered result channel.
// ----------------------------------------------------------------------------
module pkbd_back #(
  parameter int MAX_KEY_LEN = pkbd_pkg::DEF_MAX_KEY_LEN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  pkbd_pkg::cmd_t      head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output pkbd_pkg::out_word_t result_data
);
  import pkbd_pkg::*;

  localparam int AW = $clog2(MAX_KEY_LEN);

  localparam logic [1:0] ST_HEAD   = 2'd0;
  localparam logic [1:0] ST_REPLAY = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;

  logic [1:0]        state, state_next;
  logic [KLEN_W-1:0] cnt, cnt_next;
  logic              last_flag, last_flag_next;
  logic [AW-1:0]     pend_pos, pend_pos_next;

  logic [7:0]        key_mem [MAX_KEY_LEN];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  logic              out_free;
  logic              load;
  out_word_t         load_word;
  logic              at_end;

  always_comb begin
    out_free       = !result_valid || !result_stall;
    state_next     = state;
    cnt_next       = cnt;
    last_flag_next = last_flag;
    pend_pos_next  = pend_pos;
    pop            = 1'b0;
    load           = 1'b0;
    load_word      = '0;
    rd_en          = 1'b0;
    rd_addr        = pend_pos;
    wr_en          = 1'b0;
    wr_addr        = AW'(head.cnt);
    at_end         = ((KLEN_W'(pend_pos) + KLEN_W'(1)) == cnt);

    case (state)
      ST_HEAD: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          case (head.op)
            OP_KEY: begin
              load                   = 1'b1;
              load_word.item_kind    = KIND_KEY;
              load_word.out_byte     = head.data;
              load_word.key_position = 6'(head.cnt);
              load_word.entry_last   = head.last;
              wr_en                  = 1'b1;
              if (head.trunc) begin
                state_next = ST_TRUNC;
              end
            end
            OP_VALUE: begin
              load                 = 1'b1;
              load_word.item_kind  = KIND_VALUE;
              load_word.out_byte   = head.data;
              load_word.entry_last = head.last;
              if (head.trunc) begin
                state_next = ST_TRUNC;
              end
            end
            OP_MARKER: begin
              load                 = 1'b1;
              load_word.item_kind  = KIND_MARKER;
              load_word.entry_last = 1'b1;
            end
            OP_ERROR: begin
              load                 = 1'b1;
              load_word.item_kind  = KIND_ERROR;
              load_word.entry_last = 1'b1;
              load_word.error_code = head.err;
            end
            OP_REPLAY: begin
              // Fetch the first prefix byte; the replay state emits it once the output is free.
              rd_en          = 1'b1;
              rd_addr        = '0;
              pend_pos_next  = '0;
              cnt_next       = head.cnt;
              last_flag_next = head.last;
              state_next     = ST_REPLAY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REPLAY: begin
        if (out_free) begin
          load                   = 1'b1;
          load_word.item_kind    = KIND_KEY;
          load_word.out_byte     = rd_data;
          load_word.key_position = 6'(pend_pos);
          load_word.entry_last   = last_flag && at_end;
          if (at_end) begin
            state_next = ST_HEAD;
          end else begin
            rd_en         = 1'b1;
            rd_addr       = pend_pos + AW'(1);
            pend_pos_next = pend_pos + AW'(1);
          end
        end
      end
      ST_TRUNC: begin
        if (out_free) begin
          load                 = 1'b1;
          load_word.item_kind  = KIND_ERROR;
          load_word.entry_last = 1'b1;
          load_word.error_code = ERR_TRUNC;
          state_next           = ST_HEAD;
        end
      end
      default: begin
        state_next = ST_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= head.data;
    end
    if (rd_en) begin
      rd_data <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_HEAD;
      cnt       <= '0;
      last_flag <= 1'b0;
      pend_pos  <= '0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      last_flag <= last_flag_next;
      pend_pos  <= pend_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_word;
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_replay: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_HEAD))
    else $error("key memory written during a prefix replay");

  a_replay_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLAY) |-> (KLEN_W'(pend_pos) < cnt))
    else $error("replay position beyond the shared length");

  a_trunc_after_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_TRUNC) |-> $past(pop))
    else $error("truncation error raised without a command");
`endif

endmodule

// ===== rtl/prefix_key_block_entry_decoder_top.sv =====
// ----------------------------------------------------------------------------
// prefix_key_block_entry_decoder_top
// Decoder for the entry region of a prefix-compressed sorted key-value block.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_data) takes one word per cycle
//   while byte_stall is low: a region byte and a flag that marks the last byte of the
//   region. The result channel (result_valid, result_stall, result_data) gives key
//   bytes, value bytes, empty-entry markers and error words in stream order.
//   A word moves at a clock edge where valid is high and stall is low.
//   A key or value byte passes through the command queue and the output register
//   before it appears on the result channel. When an entry header completes, the
//   emitter reads the shared key prefix back from the key memory at one byte per
//   cycle while result_stall is low, and takes no other command until the prefix
//   is out. The result channel gives at most one word per cycle, and a byte that
//   also ends a truncated region is followed by a truncation error word. A four-entry
//   command queue lets the parser take one byte per cycle until the queue fills;
//   then byte_stall is held high until the emitter pops a command.
//   Reset clears the parser, the queue and the output valid flag; the key
//   memory keeps its contents, which are never read before being rewritten.
//   The last byte of a region also returns the parser to its reset state.
//   A stall on the result channel holds the output word and backs up into
//   the queue and then the byte channel.
// ----------------------------------------------------------------------------
module prefix_key_block_entry_decoder_top #(
  parameter int MAX_KEY_LEN = pkbd_pkg::DEF_MAX_KEY_LEN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  pkbd_pkg::in_word_t  byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output pkbd_pkg::out_word_t result_data
);
  import pkbd_pkg::*;

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic pop;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;

  pkbd_front #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_word  (byte_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pkbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  pkbd_back #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
